// File: design/perspective_point_projection_assert.svh
// assertion macros for the perspective point projection checker
`ifndef PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH

// same-cycle implication
`define PPP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/ppp_pkg.sv
// shared constants for the perspective point projection block
package ppp_pkg;
  localparam int COORD_W = 32;
  localparam int IDX_W = 4;
  localparam int CFG_W = 14;
  localparam int CFG_IDX_W = 2;
  localparam int NDC_LIMIT_LOG2 = 46;
  localparam int MAT_DEPTH = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic CMD_COEF = 1'b0;
  localparam logic CMD_POINT = 1'b1;
endpackage

// File: design/ppp_if.sv
// item channel interfaces for the projection block
interface ppp_in_if import ppp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [IDX_W-1:0]          coef_index;
  logic signed [COORD_W-1:0] coef_value;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  modport source (output valid, cmd, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, cmd, coef_index, coef_value, point_x, point_y, point_z,
                output ready);
endinterface

interface ppp_out_if import ppp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      visible;
  logic signed [COORD_W-1:0] screen_x;
  logic signed [COORD_W-1:0] screen_y;
  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface

// File: design/perspective_point_projection.sv
// perspective point projection: matrix transform, divide by w, viewport map
// point path: input, product, clip, divider setup, divider, multiply and output registers
// throughput: one item per cycle unless stalled; the 46-step divider is fully pipelined
// one global stall holds every stage while the output item waits
// synchronous active-low reset clears valid bits and matrix; viewport resets to 1920x1080
module perspective_point_projection import ppp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ppp_in_if.sink               in_ch,
  ppp_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);
  localparam int PW = 2 * COORD_W;
  localparam int CW = PW + 2 - FRAC_BITS;
  localparam int RW = CW + 1;
  localparam int QW = NDC_LIMIT_LOG2;
  localparam int NW = NDC_LIMIT_LOG2 + 2;
  localparam int MW = NW + CFG_W + 1;
  localparam logic signed [CW-1:0] THR = CW'(((2 ** FRAC_BITS) + 5) / 10);

  logic en;
  logic [CFG_W-1:0] width_r, height_r;
  logic signed [COORD_W-1:0] mat_r [MAT_DEPTH];

  // stage 1: input register
  logic s1_v_r, s1_cmd_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic signed [COORD_W-1:0] s1_cv_r, s1_x_r, s1_y_r, s1_z_r;

  // stage 2: products
  logic s2_v_r;
  logic signed [PW-1:0] s2_p_r [9];
  logic signed [COORD_W-1:0] s2_t_r [3];

  // stage 3: clip coordinates
  logic s3_v_r;
  logic signed [CW-1:0] s3_cx_r, s3_cy_r, s3_cw_r;

  // divider stages
  logic dv_r [QW+1];
  logic vis_r [QW+1];
  logic sx_r [QW+1];
  logic sy_r [QW+1];
  logic ox_r [QW+1];
  logic oy_r [QW+1];
  logic [CW-1:0] d_r [QW+1];
  logic [RW-1:0] rx_r [QW+1];
  logic [RW-1:0] ry_r [QW+1];
  logic [QW-1:0] nx_r [QW+1];
  logic [QW-1:0] ny_r [QW+1];
  logic [QW-1:0] qx_r [QW+1];
  logic [QW-1:0] qy_r [QW+1];

  // multiply stage
  logic m_v_r, m_vis_r;
  logic signed [MW-1:0] m_x_r, m_y_r;

  logic out_v_r, out_vis_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;

  assign en = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CFG_W'(1920);
      height_r <= CFG_W'(1080);
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) width_r <= cfg_data;
      else if (cfg_index == REG_HEIGHT) height_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r <= in_ch.cmd;
      s1_idx_r <= in_ch.coef_index;
      s1_cv_r <= in_ch.coef_value;
      s1_x_r <= in_ch.point_x;
      s1_y_r <= in_ch.point_y;
      s1_z_r <= in_ch.point_z;
    end
  end

  // coefficient writes take effect in item order at stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_DEPTH; i++) mat_r[i] <= '0;
    end else if (en && s1_v_r && s1_cmd_r == CMD_COEF) begin
      mat_r[s1_idx_r] <= s1_cv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r && s1_cmd_r == CMD_POINT;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p_r[0] <= PW'(s1_x_r) * PW'(mat_r[0]);
      s2_p_r[1] <= PW'(s1_y_r) * PW'(mat_r[1]);
      s2_p_r[2] <= PW'(s1_z_r) * PW'(mat_r[2]);
      s2_p_r[3] <= PW'(s1_x_r) * PW'(mat_r[4]);
      s2_p_r[4] <= PW'(s1_y_r) * PW'(mat_r[5]);
      s2_p_r[5] <= PW'(s1_z_r) * PW'(mat_r[6]);
      s2_p_r[6] <= PW'(s1_x_r) * PW'(mat_r[12]);
      s2_p_r[7] <= PW'(s1_y_r) * PW'(mat_r[13]);
      s2_p_r[8] <= PW'(s1_z_r) * PW'(mat_r[14]);
      s2_t_r[0] <= mat_r[3];
      s2_t_r[1] <= mat_r[7];
      s2_t_r[2] <= mat_r[15];
    end
  end

  // arithmetic shift right rounds toward minus infinity
  always_ff @(posedge clk) begin
    if (en) begin
      s3_cx_r <= CW'(s2_p_r[0] >>> FRAC_BITS) + CW'(s2_p_r[1] >>> FRAC_BITS)
               + CW'(s2_p_r[2] >>> FRAC_BITS) + CW'(s2_t_r[0]);
      s3_cy_r <= CW'(s2_p_r[3] >>> FRAC_BITS) + CW'(s2_p_r[4] >>> FRAC_BITS)
               + CW'(s2_p_r[5] >>> FRAC_BITS) + CW'(s2_t_r[1]);
      s3_cw_r <= CW'(s2_p_r[6] >>> FRAC_BITS) + CW'(s2_p_r[7] >>> FRAC_BITS)
               + CW'(s2_p_r[8] >>> FRAC_BITS) + CW'(s2_t_r[2]);
    end
  end

  // divider setup
  logic [CW-1:0] ax, ay, dd;
  logic [CW+QW-1:0] dsh;
  logic [CW+FRAC_BITS-1:0] nfx, nfy;
  always_comb begin
    ax = s3_cx_r[CW-1] ? CW'(-s3_cx_r) : CW'(s3_cx_r);
    ay = s3_cy_r[CW-1] ? CW'(-s3_cy_r) : CW'(s3_cy_r);
    dd = CW'(s3_cw_r);
    dsh = (CW+QW)'(dd) << (QW - FRAC_BITS);
    nfx = {ax, FRAC_BITS'(0)};
    nfy = {ay, FRAC_BITS'(0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r[0] <= s3_cw_r >= THR;
      sx_r[0] <= s3_cx_r[CW-1];
      sy_r[0] <= s3_cy_r[CW-1];
      ox_r[0] <= (CW+QW)'(ax) >= dsh;
      oy_r[0] <= (CW+QW)'(ay) >= dsh;
      d_r[0] <= dd;
      rx_r[0] <= RW'(ax >> (QW - FRAC_BITS));
      ry_r[0] <= RW'(ay >> (QW - FRAC_BITS));
      nx_r[0] <= nfx[QW-1:0];
      ny_r[0] <= nfy[QW-1:0];
      qx_r[0] <= '0;
      qy_r[0] <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW-1:0] tx, ty, dw;
    logic gx, gy;
    always_comb begin
      dw = RW'(d_r[k]);
      tx = {rx_r[k][RW-2:0], nx_r[k][QW-1]};
      ty = {ry_r[k][RW-2:0], ny_r[k][QW-1]};
      gx = tx >= dw;
      gy = ty >= dw;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vis_r[k+1] <= vis_r[k];
        sx_r[k+1] <= sx_r[k];
        sy_r[k+1] <= sy_r[k];
        ox_r[k+1] <= ox_r[k];
        oy_r[k+1] <= oy_r[k];
        d_r[k+1] <= d_r[k];
        rx_r[k+1] <= gx ? tx - dw : tx;
        ry_r[k+1] <= gy ? ty - dw : ty;
        nx_r[k+1] <= nx_r[k] << 1;
        ny_r[k+1] <= ny_r[k] << 1;
        qx_r[k+1] <= {qx_r[k][QW-2:0], gx};
        qy_r[k+1] <= {qy_r[k][QW-2:0], gy};
      end
    end
  end

  // ndc with clamp, then viewport scale
  logic [NW-1:0] qmx, qmy;
  logic signed [NW-1:0] ndx, ndy;
  logic [CFG_W-2:0] hw, hh;
  logic signed [CFG_W+1:0] kx, ky;
  always_comb begin
    qmx = ox_r[QW] ? NW'(1) << NDC_LIMIT_LOG2 : NW'(qx_r[QW]);
    qmy = oy_r[QW] ? NW'(1) << NDC_LIMIT_LOG2 : NW'(qy_r[QW]);
    ndx = sx_r[QW] ? -$signed(qmx) : $signed(qmx);
    ndy = sy_r[QW] ? -$signed(qmy) : $signed(qmy);
    hw = width_r[CFG_W-1:1];
    hh = height_r[CFG_W-1:1];
    kx = (CFG_W+2)'(hw) + (CFG_W+2)'(1);
    ky = (CFG_W+2)'(1) - (CFG_W+2)'(hh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= dv_r[QW];
      out_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_vis_r <= vis_r[QW];
      m_x_r <= MW'(ndx) * MW'(kx);
      m_y_r <= MW'(ndy) * MW'(ky);
    end
  end

  logic signed [MW:0] fx, fy;
  logic signed [COORD_W-1:0] satx, saty;
  localparam logic signed [MW:0] SMAX = (MW+1)'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [MW:0] SMIN = -(MW+1)'(2 ** (COORD_W - 1));
  always_comb begin
    fx = (MW+1)'(m_x_r) + ((MW+1)'(hw) << FRAC_BITS);
    fy = (MW+1)'(m_y_r) + ((MW+1)'(hh) << FRAC_BITS);
    if (fx > SMAX) satx = COORD_W'(SMAX);
    else if (fx < SMIN) satx = COORD_W'(SMIN);
    else satx = COORD_W'(fx);
    if (fy > SMAX) saty = COORD_W'(SMAX);
    else if (fy < SMIN) saty = COORD_W'(SMIN);
    else saty = COORD_W'(fy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vis_r <= m_vis_r;
      out_x_r <= m_vis_r ? satx : '0;
      out_y_r <= m_vis_r ? saty : '0;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.visible = out_vis_r;
  assign out_ch.screen_x = out_x_r;
  assign out_ch.screen_y = out_y_r;
endmodule

// File: design/ppp_checker.sv
// port-level checks for the projection block, bound to the top level
`include "perspective_point_projection_assert.svh"
module ppp_checker import ppp_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_visible,
  input logic signed [COORD_W-1:0] out_screen_x,
  input logic signed [COORD_W-1:0] out_screen_y
);
  `PPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `PPP_ASSERT_NOW(a_hidden_zero, out_valid && !out_visible, out_screen_x == 0 && out_screen_y == 0)
  `PPP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
  `PPP_ASSERT_NOW(a_stall_only_on_wait, !in_ready, out_valid && !out_ready)
endmodule

bind perspective_point_projection ppp_checker u_ppp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_visible(out_ch.visible),
  .out_screen_x(out_ch.screen_x),
  .out_screen_y(out_ch.screen_y)
);

// File: test/tb_perspective_point_projection.sv
// testbench for the perspective point projection block: directed table, random items, scoreboard
module tb_perspective_point_projection;
  import ppp_pkg::*;

  typedef struct packed {
    logic                      cmd;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] val;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } item_t;

  typedef struct packed {
    logic                      vis;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
  } proj_t;

  typedef struct {
    item_t it;
    logic  has_exp;
    proj_t exp;
  } row_t;

  localparam int FB = 16;
  localparam int LATENCY = 51;
  localparam longint LIMIT = 2000000;
  localparam logic signed [COORD_W-1:0] ONE = 32'sh0001_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  ppp_in_if in_ch ();
  ppp_out_if out_ch ();

  perspective_point_projection dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic signed [31:0] matrix [16];
  logic [CFG_W-1:0] width_reg, height_reg;
  proj_t pending [$];
  int in_idle_pct = 0, out_idle_pct = 0;
  int mismatches = 0, results_seen = 0, points_sent = 0, writes_sent = 0;
  longint cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_COEF;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint floor_q(longint p);
    return p >>> FB;
  endfunction

  function automatic longint clip_dot(int row, item_t it);
    return floor_q(longint'(it.px) * longint'(matrix[row*4]))
         + floor_q(longint'(it.py) * longint'(matrix[row*4+1]))
         + floor_q(longint'(it.pz) * longint'(matrix[row*4+2]))
         + longint'(matrix[row*4+3]);
  endfunction

  function automatic longint ndc_div(longint num, longint w);
    logic [63:0] a, q, r;
    a = (num < 0) ? -num : num;
    q = a / w;
    r = a % w;
    if (q >= (64'd1 << (NDC_LIMIT_LOG2 - FB))) q = 64'd1 << NDC_LIMIT_LOG2;
    else begin
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= w) begin
          r = r - w;
          q[0] = 1'b1;
        end
      end
    end
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic proj_t project_point(item_t it);
    proj_t r;
    longint cx, cy, cw, nx, ny, hw, hh;
    cx = clip_dot(0, it);
    cy = clip_dot(1, it);
    cw = clip_dot(3, it);
    r = '0;
    if (cw >= 6554) begin
      nx = ndc_div(cx, cw);
      ny = ndc_div(cy, cw);
      hw = width_reg / 2;
      hh = height_reg / 2;
      r.vis = 1'b1;
      r.sx = clamp32(nx * (hw + 1) + hw * 65536);
      r.sy = clamp32(ny * (1 - hh) + hh * 65536);
    end
    return r;
  endfunction

  // send one item, stalling at random per the sender idle rate
  task automatic send_item(item_t it, logic has_exp, proj_t exp_val);
    proj_t p;
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= it.cmd;
    in_ch.coef_index <= it.idx;
    in_ch.coef_value <= it.val;
    in_ch.point_x <= it.px;
    in_ch.point_y <= it.py;
    in_ch.point_z <= it.pz;
    do @(posedge clk); while (!in_ch.ready);
    if (it.cmd == CMD_COEF) begin
      matrix[it.idx] = it.val;
      writes_sent++;
    end else begin
      p = project_point(it);
      if (has_exp && p !== exp_val) begin
        mismatches++;
        if (mismatches <= 10)
          $display("predictor disagrees with table row: %h vs %h", p, exp_val);
      end
      pending.push_back(has_exp ? exp_val : p);
      points_sent++;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) width_reg = v;
    else if (idx == REG_HEIGHT) height_reg = v;
  endtask

  function automatic item_t coef(int idx, logic signed [31:0] v);
    item_t it;
    it = '0;
    it.cmd = CMD_COEF;
    it.idx = IDX_W'(idx);
    it.val = v;
    it.px = $urandom;
    return it;
  endfunction

  function automatic item_t pt(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z);
    item_t it;
    it = '0;
    it.cmd = CMD_POINT;
    it.idx = IDX_W'($urandom);
    it.val = $urandom;
    it.px = x;
    it.py = y;
    it.pz = z;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(3) == 0 ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(20 * 65536)) - 10 * 65536;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coef(bit is_w);
    case ($urandom_range(5))
      0: return $urandom;
      1: return is_w ? $signed($urandom_range(8000)) : $signed($urandom_range(1 << 20));
      default: return $signed($urandom_range(4 * 65536)) - (is_w ? 0 : 2 * 65536);
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h %h %h",
                                       out_ch.visible, out_ch.screen_x, out_ch.screen_y);
      end else begin
        proj_t e;
        e = pending.pop_front();
        if (out_ch.visible !== e.vis || out_ch.screen_x !== e.sx ||
            out_ch.screen_y !== e.sy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected vis %0d x %h y %h, got vis %0d x %h y %h",
                     e.vis, e.sx, e.sy, out_ch.visible, out_ch.screen_x, out_ch.screen_y);
        end
      end
    end
  end

  task automatic random_phase(int n);
    item_t it;
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(9) < 3) begin
        it = coef($urandom_range(15), rand_coef(1'b0));
        if (it.idx >= 12) it.val = rand_coef(1'b1);
      end else begin
        it = pt(rand_coord(), rand_coord(), rand_coord());
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  row_t dir [$];
  proj_t zero_res;
  proj_t centre;

  initial begin
    for (int i = 0; i < 16; i++) matrix[i] = 0;
    width_reg = 1920;
    height_reg = 1080;
    zero_res = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset w is zero so every point is invisible
    dir.push_back('{pt(32'sh7fffffff, 32'sh80000000, 0), 1'b1, zero_res});
    // identity-like with w = 1: origin lands at screen centre
    dir.push_back('{coef(0, ONE), 1'b0, zero_res});
    dir.push_back('{coef(5, ONE), 1'b0, zero_res});
    dir.push_back('{coef(15, ONE), 1'b0, zero_res});
    centre.vis = 1'b1;
    centre.sx = 960 * 65536;
    centre.sy = 540 * 65536;
    dir.push_back('{pt(0, 0, 0), 1'b1, centre});
    dir.push_back('{pt(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff), 1'b0, zero_res});
    dir.push_back('{pt(32'sh80000000, 32'sh7fffffff, 32'sh80000000), 1'b0, zero_res});
    // w just below and at the visibility threshold
    dir.push_back('{coef(15, 6553), 1'b0, zero_res});
    dir.push_back('{pt(ONE, ONE, 0), 1'b1, zero_res});
    dir.push_back('{coef(15, 6554), 1'b0, zero_res});
    dir.push_back('{pt(ONE, -ONE, 0), 1'b0, zero_res});
    dir.push_back('{coef(15, 32'sh80000000), 1'b0, zero_res});
    dir.push_back('{pt(5, 7, 9), 1'b1, zero_res});
    dir.push_back('{coef(14, 32'sh7fffffff), 1'b0, zero_res});
    dir.push_back('{coef(15, 0), 1'b0, zero_res});
    dir.push_back('{pt(3, -4, ONE), 1'b0, zero_res});
    dir.push_back('{pt(-1, -1, -1), 1'b0, zero_res});
    dir.push_back('{coef(2, 32'sh80000000), 1'b0, zero_res});
    dir.push_back('{coef(7, 32'sh7fffffff), 1'b0, zero_res});
    dir.push_back('{pt(ONE, 32'sh7fffffff, 2 * ONE), 1'b0, zero_res});
    dir.push_back('{pt(-ONE, 32'sh80000000, 32'sh7fffffff), 1'b0, zero_res});
    foreach (dir[i]) send_item(dir[i].it, dir[i].has_exp, dir[i].exp);

    // extreme viewport sizes, including the halves of zero and one
    write_reg(REG_WIDTH, 14'd1);
    write_reg(REG_HEIGHT, 14'd8192);
    random_phase(120);
    write_reg(REG_WIDTH, 14'd8192);
    write_reg(REG_HEIGHT, 14'd3);
    random_phase(120);
    write_reg(REG_WIDTH, 14'h3fff);
    write_reg(REG_HEIGHT, 14'd0);
    write_reg(2'd3, 14'd77);
    random_phase(100);

    in_idle_pct = 18;
    out_idle_pct = 76;
    write_reg(REG_WIDTH, 14'd640);
    write_reg(REG_HEIGHT, 14'd480);
    random_phase(450);
    in_idle_pct = 76;
    out_idle_pct = 18;
    write_reg(REG_WIDTH, CFG_W'($urandom_range(1, 8192)));
    write_reg(REG_HEIGHT, CFG_W'($urandom_range(1, 8192)));
    random_phase(450);
    in_idle_pct = 0;
    out_idle_pct = 0;
    write_reg(REG_WIDTH, 14'd1920);
    write_reg(REG_HEIGHT, 14'd1);
    random_phase(450);

    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d points and %0d coefficient writes, %0d results checked",
             points_sent, writes_sent, results_seen);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: perspective_point_projection.f
+incdir+design
design/ppp_pkg.sv
design/ppp_if.sv
design/perspective_point_projection.sv
design/ppp_checker.sv
test/tb_perspective_point_projection.sv
